/* hw/rtl/vtu_pkg.sv */
// vertex transform unit: shared types for the controller and datapath
// no dependencies
`default_nettype none

package vtu_pkg;

  typedef enum logic [1:0] {
    FN_WR_MAIN = 2'd0,
    FN_WR_OP   = 2'd1,
    FN_COMPOSE = 2'd2,
    FN_XFORM   = 2'd3
  } func_t;

  typedef struct packed {
    logic       step;
    logic [1:0] row;
    logic [1:0] k;
    logic [1:0] col;
    logic       sel_point;
    logic       wr_main;
    logic       wr_op;
    logic       cap_point;
    logic       wb_en;
    logic [3:0] wb_addr;
    logic       load_out;
  } vtu_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } vtu_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/vertex_transform_unit.sv */
// vertex transform unit top: 4x4 homogeneous Q16.16 transform engine
// element writes are taken one beat per cycle while idle; a transform
// stalls further beats until its result is loaded into the free output
// register, a compose until its write-back to the main matrix; one shared
// 32x32 multiply-accumulate forms every product of either, one per cycle
// reset: synchronous, main matrix reads as identity, operand as zeros
`default_nettype none

module vertex_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  func,
  input  wire logic        [3:0]  elem_index,
  input  wire logic signed [31:0] elem_value,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_w
);
  import vtu_pkg::*;

  vtu_cmd_t  cmd;
  vtu_stat_t stat;

  vtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vtu_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .in_w       (in_w),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w)
  );

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> in_stall)
    else $error("input taken while products in flight");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_main && cmd.wb_en))
    else $error("main matrix write port conflict");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result overwrites a stalled beat");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> stat.busy)
    else $error("issued step not tracked in pipeline");
`endif

endmodule

`default_nettype wire

/* hw/rtl/vtu_dp.sv */
// vertex transform unit datapath: main and operand matrix memories,
// shared multiply-accumulate pipeline, result row and output registers
// depends on vtu_pkg
`default_nettype none

module vtu_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vtu_pkg::vtu_cmd_t   cmd,
  output vtu_pkg::vtu_stat_t       stat,
  input  wire logic        [3:0]   elem_index,
  input  wire logic signed [31:0]  elem_value,
  input  wire logic signed [31:0]  in_x,
  input  wire logic signed [31:0]  in_y,
  input  wire logic signed [31:0]  in_z,
  input  wire logic signed [31:0]  in_w,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic signed [31:0]       out_w
);
  import vtu_pkg::*;

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

  typedef struct packed {
    logic       vld;
    logic       sel_point;
    logic       first;
    logic       last;
    logic [1:0] ridx;
  } mac_tag_t;

  logic [31:0] main_mem [16];
  logic [31:0] op_mem [16];
  logic [15:0] main_vld;
  logic [15:0] op_vld;

  logic        main_we;
  logic [3:0]  main_wa;
  logic [31:0] main_wd;
  logic [3:0]  main_ra;
  logic [3:0]  op_ra;

  logic [31:0] main_rd;
  logic [31:0] op_rd;
  logic        main_rd_vld;
  logic        main_rd_diag;
  logic        op_rd_vld;

  logic signed [31:0] pt [4];
  logic signed [31:0] pt_q;
  logic signed [31:0] res [4];

  mac_tag_t tag_a;
  mac_tag_t tag_b;
  mac_tag_t tag_c;

  logic signed [31:0]      a_val;
  logic signed [31:0]      b_val;
  logic signed [63:0]      prod;
  logic signed [63:0]      sh64;
  logic signed [ACC_W-1:0] sh;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      acc_sat;

  // matrix write and read ports
  assign main_we = cmd.wr_main | cmd.wb_en;
  assign main_wa = cmd.wb_en ? cmd.wb_addr : elem_index;
  assign main_wd = cmd.wb_en ? res[cmd.wb_addr[1:0]] : elem_value;
  assign main_ra = {cmd.row, cmd.k};
  assign op_ra   = {cmd.k, cmd.col};

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_wa] <= main_wd;
    end
    main_rd <= main_mem[main_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op) begin
      op_mem[elem_index] <= elem_value;
    end
    op_rd <= op_mem[op_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_vld <= '0;
      op_vld   <= '0;
    end else begin
      if (main_we) begin
        main_vld[main_wa] <= 1'b1;
      end
      if (cmd.wr_op) begin
        op_vld[elem_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    main_rd_vld  <= main_vld[main_ra];
    main_rd_diag <= (main_ra[3:2] == main_ra[1:0]);
    op_rd_vld    <= op_vld[op_ra];
    pt_q         <= pt[cmd.k];
    if (cmd.cap_point) begin
      pt[0] <= in_x;
      pt[1] <= in_y;
      pt[2] <= in_z;
      pt[3] <= in_w;
    end
  end

  // unwritten entries read as their reset value
  assign a_val = main_rd_vld ? main_rd : (main_rd_diag ? ONE : '0);
  assign b_val = tag_a.sel_point ? pt_q : (op_rd_vld ? op_rd : '0);

  assign sh64 = prod >>> FRAC_BITS;
  assign sh   = sh64[ACC_W-1:0];

  always_comb begin
    priority if (acc > SAT_HI) begin
      acc_sat = 32'sh7fff_ffff;
    end else if (acc < SAT_LO) begin
      acc_sat = -32'sh8000_0000;
    end else begin
      acc_sat = acc[31:0];
    end
  end

  // tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
      tag_c <= '0;
    end else begin
      tag_a.vld       <= cmd.step;
      tag_a.sel_point <= cmd.sel_point;
      tag_a.first     <= (cmd.k == 2'd0);
      tag_a.last      <= (cmd.k == 2'd3);
      tag_a.ridx      <= cmd.sel_point ? cmd.row : cmd.col;
      tag_b           <= tag_a;
      tag_c           <= tag_b;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_val * b_val;
    if (tag_b.vld) begin
      acc <= tag_b.first ? sh : acc + sh;
    end
    if (tag_c.vld && tag_c.last) begin
      res[tag_c.ridx] <= acc_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_w <= res[3];
    end
  end

  assign stat.busy     = tag_a.vld | tag_b.vld | tag_c.vld;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

/* hw/rtl/vtu_ctrl.sv */
// vertex transform unit controller: input beat decode and sequencing of
// multiply-accumulate steps, compose write-back and result hand-off
// depends on vtu_pkg
`default_nettype none

module vtu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [1:0]    func,
  output logic               in_stall,
  input  wire vtu_pkg::vtu_stat_t stat,
  output vtu_pkg::vtu_cmd_t  cmd
);
  import vtu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_WB,
    S_OUT
  } state_t;

  state_t     state;
  logic [1:0] row;
  logic [1:0] col;
  logic [1:0] k;
  logic       xform;
  logic       accept;
  func_t      fn;

  assign fn       = func_t'(func);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.step      = (state == S_RUN);
    cmd.row       = row;
    cmd.k         = k;
    cmd.col       = col;
    cmd.sel_point = xform;
    cmd.wr_main   = accept && (fn == FN_WR_MAIN);
    cmd.wr_op     = accept && (fn == FN_WR_OP);
    cmd.cap_point = accept && (fn == FN_XFORM);
    cmd.wb_en     = (state == S_WB);
    cmd.wb_addr   = {row, col};
    cmd.load_out  = (state == S_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
      xform <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (fn == FN_COMPOSE || fn == FN_XFORM)) begin
            state <= S_RUN;
            xform <= (fn == FN_XFORM);
            row   <= '0;
            col   <= '0;
            k     <= '0;
          end
        end
        S_RUN: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            if (xform) begin
              row <= row + 2'd1;
              if (row == 2'd3) begin
                state <= S_DRAIN;
              end
            end else begin
              col <= col + 2'd1;
              if (col == 2'd3) begin
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          if (!stat.busy) begin
            state <= xform ? S_OUT : S_WB;
          end
        end
        S_WB: begin
          col <= col + 2'd1;
          if (col == 2'd3) begin
            if (row == 2'd3) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 2'd1;
              state <= S_RUN;
            end
          end
        end
        S_OUT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
